FILE: rtl/gsks_pkg.sv
// Package for the gated scalar scale estimator: constants, codes, the control state type and the scale clamp.
`timescale 1ns / 1ps

package gsks_pkg;

  // Field widths
  localparam int unsigned ScaleW = 29;
  localparam int unsigned VarW   = 31;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 4;

  // Q8.24 constants
  localparam logic [ScaleW-1:0] SCALE_MIN   = 29'd83886;      // 0.005
  localparam logic [ScaleW-1:0] SCALE_MAX   = 29'd335544320;  // 20.0
  localparam logic [ScaleW-1:0] SCALE_RESET = 29'd3355443;    // 0.2
  localparam logic [31:0]       CONF_BIAS   = 32'd167772;     // 0.01
  localparam logic [37:0]       R_FLOOR     = 38'd16777;      // 0.001
  localparam logic [VarW-1:0]   VAR_INIT    = 31'd4194304;    // 0.25
  localparam logic [VarW-1:0]   VAR_MAX     = 31'h7FFF_FFFF;
  localparam logic [24:0]       ONE_Q       = 25'd16777216;   // 1.0
  localparam logic [31:0]       OBS_MIN     = 32'd83886;

  // Config reset values
  localparam logic [VarW-1:0] PROC_NOISE_RESET = 31'd1678;
  localparam logic [VarW-1:0] MEAS_BASE_RESET  = 31'd1677722;

  // Zero-velocity decay 99/100
  localparam logic [37:0] ZV_NUM = 38'd99;
  localparam logic [38:0] ZV_DEN = 39'd100;

  // Iteration counts of the serial divider and multiplier
  localparam logic [5:0] DIV_R_STEPS  = 6'd38;
  localparam logic [5:0] DIV_K_STEPS  = 6'd24;
  localparam logic [5:0] DIV_Z_STEPS  = 6'd31;
  localparam logic [5:0] MUL_SQ_STEPS = 6'd32;
  localparam logic [5:0] MUL_K_STEPS  = 6'd25;

  typedef enum logic [1:0] {
    CMD_UPDATE   = 2'd0,
    CMD_ZERO_VEL = 2'd1,
    CMD_RESTART  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_INVALID   = 3'd1,
    ST_GATED     = 3'd2,
    ST_ZERO_VEL  = 3'd3,
    ST_RESTARTED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_INIT_SCALE = 2'd0,
    REG_PROC_NOISE = 2'd1,
    REG_MEAS_BASE  = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_R,
    S_SUM,
    S_MUL_SQ,
    S_GATE,
    S_DIV_K,
    S_MUL_KI,
    S_SCALE,
    S_MUL_V,
    S_DIV_Z,
    S_DONE
  } state_e;

  // Clamp a signed scale candidate to [SCALE_MIN, SCALE_MAX]
  function automatic logic [ScaleW-1:0] clamp_scale(input logic signed [33:0] s);
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    lo = $signed({5'b0, SCALE_MIN});
    hi = $signed({5'b0, SCALE_MAX});
    if (s < lo) begin
      clamp_scale = SCALE_MIN;
    end else if (s > hi) begin
      clamp_scale = SCALE_MAX;
    end else begin
      clamp_scale = s[ScaleW-1:0];
    end
  endfunction

endpackage

FILE: rtl/gated_scalar_kalman_scale.sv
// Top level: one-state Kalman scale estimator with innovation gate, bit-serial datapath.
// One item at a time: the next input is taken the cycle after the result loads into the
// output register, which an output stall can hold back. The datapath is a shared radix-2
// divider (38, 24 or 31 steps) and a shared shift-add multiplier (32 + 25 + 25 steps).
// Reset: async active low; scale 0.2, variance 0.25, registers to their defaults, no result.
`timescale 1ns / 1ps

module gated_scalar_kalman_scale (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input item channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      command_i,
  input  logic signed [31:0]              observed_scale_i,
  input  logic signed [31:0]              confidence_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gsks_pkg::ScaleW-1:0]     scale_estimate_o,
  output logic [gsks_pkg::VarW-1:0]       scale_variance_o,
  output logic [2:0]                      status_o,
  // APB config port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gsks_pkg::AddrW-1:0]      paddr,
  input  logic [gsks_pkg::DataW-1:0]      pwdata,
  output logic [gsks_pkg::DataW-1:0]      prdata,
  output logic                            pready
);

  import gsks_pkg::*;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [ScaleW-1:0] init_scale_q;
  logic [VarW-1:0]   proc_noise_q;
  logic [VarW-1:0]   meas_base_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_scale_q <= SCALE_RESET;
      proc_noise_q <= PROC_NOISE_RESET;
      meas_base_q  <= MEAS_BASE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_INIT_SCALE: init_scale_q <= pwdata[ScaleW-1:0];
        REG_PROC_NOISE: proc_noise_q <= pwdata[VarW-1:0];
        REG_MEAS_BASE:  meas_base_q  <= pwdata[VarW-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_INIT_SCALE: prdata = {3'b0, init_scale_q};
      REG_PROC_NOISE: prdata = {1'b0, proc_noise_q};
      REG_MEAS_BASE:  prdata = {1'b0, meas_base_q};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control and estimator state
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [ScaleW-1:0] scale_q, scale_d;    // scale estimate
  logic [VarW-1:0]   var_q, var_d;        // estimate variance
  logic              out_valid_q, out_valid_d;

  // Item and intermediate payload (no reset needed)
  logic [1:0]        cmd_q;
  logic [31:0]       obs_q, conf_q;
  logic [31:0]       mag_q, mag_d;        // |innovation|
  logic              neg_q, neg_d;        // innovation sign
  logic [38:0]       s_q, s_d;            // S = P + R
  logic [39:0]       s9_q, s9_d;          // 9*S, modulo 2^40
  logic [23:0]       k_q, k_d;            // gain
  logic [31:0]       step_q, step_d;      // rounded scale correction
  status_e           status_q, status_d;

  // Shared radix-2 restoring divider
  logic [38:0]       rem_q, rem_d;
  logic [37:0]       quo_q, quo_d;        // dividend bits in, quotient bits out
  logic [38:0]       dvs_q, dvs_d;
  // Shared shift-add multiplier
  logic [31:0]       mc_q, mc_d;
  logic [31:0]       hi_q, hi_d;
  logic [31:0]       lo_q, lo_d;
  // Iteration counter, shared by both units
  logic [5:0]        cnt_q, cnt_d;

  // Output register
  logic [ScaleW-1:0] out_scale_q;
  logic [VarW-1:0]   out_var_q;
  status_e           out_status_q;
  logic              out_load;

  logic in_xfer, out_xfer;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  // divider step: shift in the next dividend bit, trial subtract
  logic [39:0] rem_sh;
  logic [40:0] div_diff;
  logic [38:0] div_rem_nx;
  logic [37:0] div_quo_nx;

  assign rem_sh   = {rem_q, quo_q[37]};
  assign div_diff = {1'b0, rem_sh} - {2'b0, dvs_q};

  always_comb begin
    if (!div_diff[40]) begin
      div_rem_nx = div_diff[38:0];
      div_quo_nx = {quo_q[36:0], 1'b1};
    end else begin
      div_rem_nx = rem_sh[38:0];
      div_quo_nx = {quo_q[36:0], 1'b0};
    end
  end

  // multiplier step: conditional add, shift right; low product bits land in lo
  logic [32:0] mul_sum;
  logic [31:0] mul_hi_nx, mul_lo_nx;

  assign mul_sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : 33'd0);
  assign mul_hi_nx = mul_sum[32:1];
  assign mul_lo_nx = {mul_sum[0], lo_q[31:1]};

  // 25-step product P: P >> 24 = {hi, lo[31]}, P mod 2^24 = lo[30:7]
  logic [32:0] prod25_top;
  logic        prod25_frac_nz;
  assign prod25_top     = {hi_q, lo_q[31]};
  assign prod25_frac_nz = |lo_q[30:7];

  // 32-step square: innov^2 >> 24 and its fraction
  logic [39:0] sq_top;
  logic        sq_frac_nz;
  assign sq_top     = {hi_q, lo_q[31:24]};
  assign sq_frac_nz = |lo_q[23:0];

  // combinational arithmetic for the decode, sum and scale states
  logic [31:0]        var_sum;
  logic [VarW-1:0]    var_sat;
  logic signed [32:0] innov;
  logic [32:0]        innov_abs;
  logic               reject;
  logic [37:0]        zv_dividend;
  logic [37:0]        r_floored;
  logic signed [33:0] scale_cand;

  assign var_sum   = {1'b0, var_q} + {1'b0, proc_noise_q};
  assign var_sat   = var_sum[31] ? VAR_MAX : var_sum[VarW-1:0];
  assign innov     = $signed({obs_q[31], obs_q}) - $signed({4'b0, scale_q});
  assign innov_abs = innov[32] ? 33'(-innov) : 33'(innov);
  assign reject    = ($signed(obs_q) <= $signed(OBS_MIN)) || conf_q[31] || (conf_q == 32'd0);
  assign zv_dividend = 38'(var_q) * ZV_NUM;
  assign r_floored = (quo_q < R_FLOOR) ? R_FLOOR : quo_q;
  assign scale_cand = neg_q ? ($signed({5'b0, scale_q}) - $signed({2'b0, step_q}))
                            : ($signed({5'b0, scale_q}) + $signed({2'b0, step_q}));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    scale_d     = scale_q;
    var_d       = var_q;
    out_valid_d = out_valid_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    s_d         = s_q;
    s9_d        = s9_q;
    k_d         = k_q;
    step_d      = step_q;
    status_d    = status_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvs_d       = dvs_q;
    mc_d        = mc_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    cnt_d       = cnt_q;
    out_load    = 1'b0;

    if (out_xfer) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (cmd_e'(cmd_q))
          CMD_UPDATE: begin
            if (reject) begin
              status_d = ST_INVALID;
              state_d  = S_DONE;
            end else begin
              // process noise first; kept even if the item is gated out
              var_d = var_sat;
              neg_d = innov[32];
              mag_d = innov_abs[31:0];
              // R = (base << 24) / (conf + 0.01); top 17 dividend bits preload the remainder
              rem_d = 39'(meas_base_q[30:14]);
              quo_d = {meas_base_q[13:0], 24'd0};
              dvs_d = {7'd0, conf_q + CONF_BIAS};
              cnt_d = DIV_R_STEPS;
              state_d = S_DIV_R;
            end
          end
          CMD_ZERO_VEL: begin
            // P * 99 / 100
            rem_d   = 39'(zv_dividend[37:31]);
            quo_d   = {zv_dividend[30:0], 7'd0};
            dvs_d   = ZV_DEN;
            cnt_d   = DIV_Z_STEPS;
            state_d = S_DIV_Z;
          end
          CMD_RESTART: begin
            scale_d  = clamp_scale($signed({5'b0, init_scale_q}));
            var_d    = VAR_INIT;
            status_d = ST_RESTARTED;
            state_d  = S_DONE;
          end
          default: begin
            status_d = ST_INVALID;  // reserved command
            state_d  = S_DONE;
          end
        endcase
      end

      S_DIV_R: begin
        if (cnt_q != 6'd0) begin
          rem_d = div_rem_nx;
          quo_d = div_quo_nx;
          cnt_d = cnt_q - 6'd1;
        end else begin
          state_d = S_SUM;
        end
      end

      S_SUM: begin
        s_d = {8'd0, var_q} + {1'b0, r_floored};
        // innov^2
        mc_d    = mag_q;
        hi_d    = '0;
        lo_d    = mag_q;
        cnt_d   = MUL_SQ_STEPS;
        state_d = S_MUL_SQ;
      end

      S_MUL_SQ: begin
        // 9*S kept to 40 bits, so 9*S*2^24 wraps at 64 bits
        s9_d = {s_q[36:0], 3'd0} + {1'b0, s_q};
        if (cnt_q != 6'd0) begin
          hi_d  = mul_hi_nx;
          lo_d  = mul_lo_nx;
          cnt_d = cnt_q - 6'd1;
        end else begin
          state_d = S_GATE;
        end
      end

      S_GATE: begin
        // innov^2 > (9*S*2^24 mod 2^64), tested only while S < 2^38
        if (!s_q[38] && ((sq_top > s9_q) || ((sq_top == s9_q) && sq_frac_nz))) begin
          status_d = ST_GATED;
          state_d  = S_DONE;
        end else begin
          // K = (P << 24) / S; P < S so P itself preloads the remainder
          rem_d   = 39'(var_q);
          quo_d   = '0;
          dvs_d   = s_q;
          cnt_d   = DIV_K_STEPS;
          state_d = S_DIV_K;
        end
      end

      S_DIV_K: begin
        if (cnt_q != 6'd0) begin
          rem_d = div_rem_nx;
          quo_d = div_quo_nx;
          cnt_d = cnt_q - 6'd1;
        end else begin
          k_d     = quo_q[23:0];
          mc_d    = mag_q;
          hi_d    = '0;
          lo_d    = {8'd0, quo_q[23:0]};
          cnt_d   = MUL_K_STEPS;
          state_d = S_MUL_KI;
        end
      end

      S_MUL_KI: begin
        if (cnt_q != 6'd0) begin
          hi_d  = mul_hi_nx;
          lo_d  = mul_lo_nx;
          cnt_d = cnt_q - 6'd1;
        end else begin
          // negative innovation rounds the step up so the update floors
          step_d  = 32'(prod25_top + {32'd0, (neg_q && prod25_frac_nz)});
          state_d = S_SCALE;
        end
      end

      S_SCALE: begin
        scale_d = clamp_scale(scale_cand);
        // (1 - K) * P
        mc_d    = {1'b0, var_q};
        hi_d    = '0;
        lo_d    = {7'd0, ONE_Q - {1'b0, k_q}};
        cnt_d   = MUL_K_STEPS;
        state_d = S_MUL_V;
      end

      S_MUL_V: begin
        if (cnt_q != 6'd0) begin
          hi_d  = mul_hi_nx;
          lo_d  = mul_lo_nx;
          cnt_d = cnt_q - 6'd1;
        end else begin
          var_d    = prod25_top[VarW-1:0];
          status_d = ST_ACCEPTED;
          state_d  = S_DONE;
        end
      end

      S_DIV_Z: begin
        if (cnt_q != 6'd0) begin
          rem_d = div_rem_nx;
          quo_d = div_quo_nx;
          cnt_d = cnt_q - 6'd1;
        end else begin
          var_d    = quo_q[VarW-1:0];
          status_d = ST_ZERO_VEL;
          state_d  = S_DONE;
        end
      end

      S_DONE: begin
        // hand the result over once the output register is free or draining
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scale_q     <= SCALE_RESET;
      var_q       <= VAR_INIT;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      scale_q     <= scale_d;
      var_q       <= var_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= command_i;
      obs_q  <= observed_scale_i;
      conf_q <= confidence_i;
    end
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    s_q      <= s_d;
    s9_q     <= s9_d;
    k_q      <= k_d;
    step_q   <= step_d;
    status_q <= status_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    dvs_q    <= dvs_d;
    mc_q     <= mc_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    if (out_load) begin
      out_scale_q  <= scale_q;
      out_var_q    <= var_q;
      out_status_q <= status_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign scale_estimate_o = out_scale_q;
  assign scale_variance_o = out_var_q;
  assign status_o         = out_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scale_q >= SCALE_MIN) && (scale_q <= SCALE_MAX))
    else $error("scale estimate left its clamp range");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIV_R) || (state_q == S_DIV_K) || (state_q == S_DIV_Z)) |->
    (rem_q < dvs_q))
    else $error("divider partial remainder not below divisor");

  a_take_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DECODE))
    else $error("accepted item not decoded next cycle");

  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) |=>
    (out_valid_q && (state_q == S_IDLE)))
    else $error("finished result not moved to output register");

endmodule

FILE: dv/gsks_checker.sv
// Scoreboard for the scale estimator: watches both channels and config writes, predicts, compares.
`timescale 1ns / 1ps

module gsks_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    command_i,
  input  logic signed [31:0]            observed_scale_i,
  input  logic signed [31:0]            confidence_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [gsks_pkg::ScaleW-1:0]   scale_estimate_i,
  input  logic [gsks_pkg::VarW-1:0]     scale_variance_i,
  input  logic [2:0]                    status_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [gsks_pkg::AddrW-1:0]    paddr_i,
  input  logic [gsks_pkg::DataW-1:0]    pwdata_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  import gsks_pkg::*;

  localparam longint unsigned QONE = 64'd1 << 24;

  typedef struct packed {
    logic [ScaleW-1:0] scale;
    logic [VarW-1:0]   variance;
    logic [2:0]        status;
  } estimate_t;

  estimate_t expected_q[$];
  estimate_t oldest;
  estimate_t predicted;

  // Predictor copy of the block state and its registers
  logic [ScaleW-1:0] est_scale;
  logic [VarW-1:0]   est_var;
  logic [ScaleW-1:0] cfg_init_scale;
  logic [VarW-1:0]   cfg_proc_noise;
  logic [VarW-1:0]   cfg_meas_base;

  function automatic logic [ScaleW-1:0] bound_scale(input longint v);
    if (v < longint'(SCALE_MIN)) return SCALE_MIN;
    if (v > longint'(SCALE_MAX)) return SCALE_MAX;
    return v[ScaleW-1:0];
  endfunction

  // One filter step; the returned scale and variance are also the next state.
  function automatic estimate_t kalman_step(input logic [1:0] cmd,
                                            input logic signed [31:0] obs,
                                            input logic signed [31:0] conf,
                                            input logic [ScaleW-1:0] scale,
                                            input logic [VarW-1:0] var_in);
    estimate_t       res;
    longint unsigned p, r, s, k, mag, step, tmp;
    longint          innov;
    res.scale    = scale;
    res.variance = var_in;
    res.status   = ST_INVALID;
    case (cmd)
      CMD_UPDATE: begin
        if (longint'(obs) > longint'(SCALE_MIN) && conf > 0) begin
          p = 64'(var_in) + 64'(cfg_proc_noise);
          if (p > 64'(VAR_MAX)) p = 64'(VAR_MAX);
          res.variance = p[VarW-1:0];
          r = (64'(cfg_meas_base) << 24) / (64'(conf) + 64'(CONF_BIAS));
          if (r < 64'(R_FLOOR)) r = 64'(R_FLOOR);
          s = p + r;
          innov = longint'(obs) - longint'(scale);
          if (innov < 0) mag = -innov;
          else mag = innov;
          // gate product is taken modulo 2^64
          if (s < (64'd1 << 38) && mag * mag > 64'd9 * s * QONE) begin
            res.status = ST_GATED;
          end else begin
            k = (p << 24) / s;
            if (innov < 0) begin
              step = (k * mag + QONE - 64'd1) >> 24;
              res.scale = bound_scale(longint'(scale) - longint'(step));
            end else begin
              step = (k * mag) >> 24;
              res.scale = bound_scale(longint'(scale) + longint'(step));
            end
            tmp = ((QONE - k) * p) >> 24;
            res.variance = tmp[VarW-1:0];
            res.status = ST_ACCEPTED;
          end
        end
      end
      CMD_ZERO_VEL: begin
        tmp = (64'(var_in) * 64'd99) / 64'd100;
        res.variance = tmp[VarW-1:0];
        res.status = ST_ZERO_VEL;
      end
      CMD_RESTART: begin
        res.scale    = bound_scale(longint'(cfg_init_scale));
        res.variance = VAR_INIT;
        res.status   = ST_RESTARTED;
      end
      default: res.status = ST_INVALID;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_scale      = SCALE_RESET;
      est_var        = VAR_INIT;
      cfg_init_scale = SCALE_RESET;
      cfg_proc_noise = PROC_NOISE_RESET;
      cfg_meas_base  = MEAS_BASE_RESET;
      expected_q.delete();
      fail_count_o   = 0;
      pending_o      = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[AddrW-1:2])
          REG_INIT_SCALE: cfg_init_scale = pwdata_i[ScaleW-1:0];
          REG_PROC_NOISE: cfg_proc_noise = pwdata_i[VarW-1:0];
          REG_MEAS_BASE:  cfg_meas_base  = pwdata_i[VarW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: scale_estimate %0d scale_variance %0d status %0d",
                 scale_estimate_i, scale_variance_i, status_i);
          fail_count_o++;
        end else begin
          oldest = expected_q[0];
          expected_q.delete(0);
          if (scale_estimate_i !== oldest.scale) begin
            $error("scale_estimate mismatch: expected %0d, actual %0d",
                   oldest.scale, scale_estimate_i);
            fail_count_o++;
          end
          if (scale_variance_i !== oldest.variance) begin
            $error("scale_variance mismatch: expected %0d, actual %0d",
                   oldest.variance, scale_variance_i);
            fail_count_o++;
          end
          if (status_i !== oldest.status) begin
            $error("status mismatch: expected %0d, actual %0d", oldest.status, status_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predicted = kalman_step(command_i, observed_scale_i, confidence_i, est_scale, est_var);
        est_scale = predicted.scale;
        est_var   = predicted.variance;
        expected_q.insert(expected_q.size(), predicted);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the scale estimator: clock, reset, stimulus, register setup and verdict.
`timescale 1ns / 1ps

module tb_top;
  import gsks_pkg::*;

  // command code the block must treat as reserved, and an unmapped register slot
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam logic [1:0] REG_UNUSED   = 2'd3;

  // Q8.24 values used by the directed part
  localparam int Q_ONE     = 16777216;
  localparam int Q_THIRTY  = 503316480;
  localparam int Q_SIXTY   = 1006632960;
  localparam int Q_NEG_MAX = 32'sh8000_0000;
  localparam int Q_POS_MAX = 32'sh7FFF_FFFF;

  localparam int RANDOM_PHASES   = 5;
  localparam int ITEMS_PER_PHASE = 255;
  localparam int DRAIN_CYCLES    = 200;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          command_i;
  logic signed [31:0]  observed_scale_i;
  logic signed [31:0]  confidence_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ScaleW-1:0]   scale_estimate_o;
  logic [VarW-1:0]     scale_variance_o;
  logic [2:0]          status_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  int fail_count;
  int pending_results;
  bit quiet;   // when set, neither side inserts idle cycles

  gated_scalar_kalman_scale dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .observed_scale_i (observed_scale_i),
    .confidence_i     (confidence_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .scale_estimate_o (scale_estimate_o),
    .scale_variance_o (scale_variance_o),
    .status_o         (status_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  gsks_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .command_i        (command_i),
    .observed_scale_i (observed_scale_i),
    .confidence_i     (confidence_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .scale_estimate_i (scale_estimate_o),
    .scale_variance_i (scale_variance_o),
    .status_i         (status_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .fail_count_o     (fail_count),
    .pending_o        (pending_results)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run: about 1300 items, each with the longest
  // sender gap and receiver stall.
  initial begin
    #30_000_000;
    $display("gated_scalar_kalman_scale test failed");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 40) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Result-side backpressure: stall bursts separated by short open windows.
  initial begin
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = idle_len();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  // One input transfer. Valid stays high across back-to-back items; the payload
  // changes only at the falling edge after the previous transfer.
  task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] obs,
                           input logic signed [31:0] conf);
    int gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    observed_scale_i <= obs;
    confidence_i     <= conf;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Register set for one random phase; occasionally full-width noise so every
  // register bit toggles, otherwise plausible filter tuning.
  task automatic load_random_settings();
    logic [31:0] init_val;
    int          shift;
    if ($urandom_range(0, 3) == 0) init_val = $urandom & 32'h1FFF_FFFF;
    else init_val = $urandom_range(1677722, 167772160);
    cfg_write(REG_INIT_SCALE, init_val);
    shift = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : $urandom_range(14, 31);
    cfg_write(REG_PROC_NOISE, $urandom >> shift);
    shift = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(4, 14);
    cfg_write(REG_MEAS_BASE, $urandom >> shift);
  endtask

  // Mostly sane measurements around the phase target so the filter converges and
  // gain/variance updates get exercised; the rest is events, outliers and junk.
  task automatic drive_random_item(input int target);
    int                 pick;
    int                 spread;
    logic [1:0]         cmd;
    logic signed [31:0] obs;
    logic signed [31:0] conf;
    pick   = $urandom_range(0, 99);
    cmd    = CMD_UPDATE;
    spread = ($urandom_range(0, 3) == 0) ? (1 << 25) : (1 << 22);
    obs    = target + int'($urandom_range(0, 2 * spread)) - spread;
    conf   = $urandom_range(1 << 18, 1 << 28);
    if (pick >= 70 && pick < 78) begin
      cmd = CMD_ZERO_VEL;
    end else if (pick >= 78 && pick < 82) begin
      cmd = CMD_RESTART;
    end else if (pick >= 82 && pick < 88) begin
      // outlier, gated unless the noise terms are huge
      obs = target + int'($urandom_range(1 << 26, 1 << 30));
    end else if (pick >= 88 && pick < 94) begin
      obs  = $urandom;
      conf = $urandom;
    end else if (pick >= 94 && pick < 97) begin
      // rejected: scale at/below the floor or non-positive confidence
      if ($urandom_range(0, 1) == 0) begin
        obs = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 83886)) : -int'($urandom);
      end else begin
        conf = -int'($urandom_range(0, 32'h7FFF_FFFF));
      end
    end else if (pick >= 97) begin
      cmd = CMD_RESERVED;
    end
    send_item(cmd, obs, conf);
  endtask

  initial begin
    int target;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    command_i        = CMD_UPDATE;
    observed_scale_i = '0;
    confidence_i     = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    quiet            = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset defaults: field extremes, reject boundaries, every command.
    send_item(CMD_UPDATE, Q_ONE, Q_ONE);
    send_item(CMD_UPDATE, 83886, Q_ONE);            // scale exactly at the floor: rejected
    send_item(CMD_UPDATE, 83887, Q_ONE);            // just above the floor
    send_item(CMD_UPDATE, Q_NEG_MAX, Q_ONE);
    send_item(CMD_UPDATE, Q_POS_MAX, Q_ONE);        // far outlier: gated
    send_item(CMD_UPDATE, Q_ONE, 0);                // zero confidence: rejected
    send_item(CMD_UPDATE, Q_ONE, -1);
    send_item(CMD_UPDATE, Q_ONE, Q_NEG_MAX);
    send_item(CMD_UPDATE, Q_ONE, Q_POS_MAX);        // tiny R, floored
    send_item(CMD_UPDATE, Q_ONE, 1);                // huge R
    send_item(CMD_ZERO_VEL, '0, '0);
    send_item(CMD_RESERVED, Q_ONE, Q_ONE);
    send_item(CMD_RESTART, '0, '0);
    drain_results();

    // All registers at the top: variance saturates, scale clamps at 20,
    // restart value above range gets clamped.
    cfg_write(REG_INIT_SCALE, 32'h1FFF_FFFF);
    cfg_write(REG_PROC_NOISE, 32'h7FFF_FFFF);
    cfg_write(REG_MEAS_BASE, 32'h7FFF_FFFF);
    send_item(CMD_UPDATE, Q_SIXTY, Q_ONE);
    send_item(CMD_UPDATE, Q_THIRTY, 1);
    send_item(CMD_ZERO_VEL, '0, '0);
    send_item(CMD_UPDATE, Q_POS_MAX, Q_POS_MAX);
    send_item(CMD_RESTART, '0, '0);
    drain_results();

    // All registers at zero: R floor, restart below range; write to the
    // unmapped slot must not disturb anything.
    cfg_write(REG_INIT_SCALE, '0);
    cfg_write(REG_PROC_NOISE, '0);
    cfg_write(REG_MEAS_BASE, '0);
    cfg_write(REG_UNUSED, $urandom);
    send_item(CMD_RESTART, '0, '0);
    send_item(CMD_UPDATE, Q_ONE, Q_ONE);
    send_item(CMD_UPDATE, 83887, Q_ONE);
    send_item(CMD_ZERO_VEL, '0, '0);
    send_item(CMD_RESERVED, '0, '0);
    drain_results();

    // Random phases, each with its own register set and target scale;
    // one phase runs with no idle cycles on either side.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_random_settings();
      quiet  = (phase == 2);
      target = $urandom_range(1677722, 167772160);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        drive_random_item(target);
      end
      drain_results();
    end
    quiet = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("gated_scalar_kalman_scale test passed");
    end else begin
      $display("gated_scalar_kalman_scale test failed");
    end
    $finish;
  end

endmodule
